@@ sv/sva_pkg.sv @@
// Shared types, constants and the envelope step function for the voice allocator.
// Depends on nothing; the engine and the top level refer to it by scoped names.
package sva_pkg;

    localparam int VOICES_DEF = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_COUNT = 8;
    localparam int CFG_IW = 3;

    localparam logic [15:0] FULL_LEVEL = 16'd32768;
    localparam logic [15:0] QUIET_MAX = 16'd32;
    localparam logic [15:0] NEAR_FULL = 16'd32441;

    localparam logic [CFG_IW-1:0] CFG_AMP_ATTACK = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_AMP_DECAY = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_AMP_SUSTAIN = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_AMP_RELEASE = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_FILT_ATTACK = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_FILT_DECAY = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_FILT_SUSTAIN = 3'd6;
    localparam logic [CFG_IW-1:0] CFG_FILT_RELEASE = 3'd7;

    localparam logic [15:0] CFG_RESET [CFG_COUNT] =
        '{16'd328, 16'd33, 16'd22938, 16'd33, 16'd328, 16'd33, 16'd16384, 16'd33};

    typedef enum logic [1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_ALL_OFF  = 2'd2,
        OP_TICK     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_ATTACK  = 2'd0,
        ST_DECAY   = 2'd1,
        ST_SUSTAIN = 2'd2,
        ST_RELEASE = 2'd3
    } t_stage;

    typedef enum logic [1:0] {
        KIND_ASSIGN = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_ACK    = 2'd2
    } t_kind;

    typedef struct packed {
        t_op        op;
        logic [6:0] note;
        logic [6:0] velocity;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  voice;
        logic        active;
        logic [6:0]  voice_note;
        logic [6:0]  voice_velocity;
        logic [15:0] amp_level;
        logic [15:0] filter_level;
        t_stage      amp_stage;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] level;
        t_stage      stage;
    } t_env;

    typedef struct packed {
        logic idle;
        logic res_push;
    } t_eng_stat;

    // One tick of a linear ADSR envelope.
    function automatic t_env env_step(t_env e, logic key, logic [15:0] att,
                                      logic [15:0] dec, logic [15:0] sus,
                                      logic [15:0] rel);
        logic [16:0] sum;
        t_env r;
        r = e;
        sum = {1'b0, e.level} + {1'b0, att};
        case (e.stage)
            ST_ATTACK: begin
                if (sum >= {1'b0, FULL_LEVEL}) begin
                    r.level = FULL_LEVEL;
                    r.stage = ST_DECAY;
                end else begin
                    r.level = sum[15:0];
                end
            end
            ST_DECAY: begin
                sum = {1'b0, dec} + {1'b0, sus};
                if ({1'b0, e.level} <= sum) begin
                    r.level = sus;
                    r.stage = ST_SUSTAIN;
                end else begin
                    r.level = e.level - dec;
                end
            end
            ST_SUSTAIN: begin
                if (!key) r.stage = ST_RELEASE;
            end
            default: begin
                r.level = (e.level <= rel) ? 16'd0 : e.level - rel;
            end
        endcase
        return r;
    endfunction

endpackage

@@ sv/sva_fifo.sv @@
// Small first-in first-out queue of packed items.
// Depends on nothing beyond its type parameter.
module sva_fifo #(
    parameter type T = logic,
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    T r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0] r_count;
    logic do_push;
    logic do_pop;

    assign o_full = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_mem[r_wr] <= i_data;
                r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            if (do_push && !do_pop) r_count <= r_count + 1'b1;
            else if (!do_push && do_pop) r_count <= r_count - 1'b1;
        end
    end
endmodule

@@ sv/sva_engine.sv @@
// Back end of the voice allocator: voice slot state, configuration registers and
// the per-slot sequencer. Depends on sva_pkg.
module sva_engine #(
    parameter int VOICES = sva_pkg::VOICES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [sva_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [15:0]             i_cfg_data,
    input  logic                    i_cmd_valid,
    input  sva_pkg::t_in_item       i_cmd,
    output logic                    o_cmd_take,
    output sva_pkg::t_out_item      o_res,
    input  logic                    i_res_full,
    output sva_pkg::t_eng_stat      o_stat
);
    localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;

    typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_SCAN, S_ASSIGN} t_state;

    t_state r_state;
    sva_pkg::t_in_item r_cmd;
    logic [IW-1:0] r_idx;
    logic [15:0] r_cfg [sva_pkg::CFG_COUNT];

    logic        r_on   [VOICES];
    logic [6:0]  r_note [VOICES];
    logic [6:0]  r_vel  [VOICES];
    logic [15:0] r_alvl [VOICES];
    sva_pkg::t_stage r_astg [VOICES];
    logic        r_akey [VOICES];
    logic [15:0] r_flvl [VOICES];
    sva_pkg::t_stage r_fstg [VOICES];
    logic        r_fkey [VOICES];

    logic r_same_found, r_free_found, r_quiet_found;
    logic [IW-1:0] r_free_idx, r_quiet_idx, r_rel_idx, r_min_idx;
    logic [15:0] r_rel_low, r_min_low;

    logic last_idx;
    logic c_on, n_on, n_akey, n_fkey, force_rel, match;
    sva_pkg::t_env c_a, c_f, n_a, n_f, t_a, t_f;
    sva_pkg::t_stage eff_stg;
    logic [IW-1:0] pick;
    logic [15:0] cfg_sat;

    assign last_idx = (r_idx == IW'(VOICES-1));
    assign cfg_sat = (i_cfg_data > sva_pkg::FULL_LEVEL) ? sva_pkg::FULL_LEVEL : i_cfg_data;

    always_comb begin
        c_on = r_on[r_idx];
        c_a = '{level: r_alvl[r_idx], stage: r_astg[r_idx]};
        c_f = '{level: r_flvl[r_idx], stage: r_fstg[r_idx]};
        t_a = sva_pkg::env_step(c_a, r_akey[r_idx], r_cfg[sva_pkg::CFG_AMP_ATTACK],
                  r_cfg[sva_pkg::CFG_AMP_DECAY], r_cfg[sva_pkg::CFG_AMP_SUSTAIN],
                  r_cfg[sva_pkg::CFG_AMP_RELEASE]);
        t_f = sva_pkg::env_step(c_f, r_fkey[r_idx], r_cfg[sva_pkg::CFG_FILT_ATTACK],
                  r_cfg[sva_pkg::CFG_FILT_DECAY], r_cfg[sva_pkg::CFG_FILT_SUSTAIN],
                  r_cfg[sva_pkg::CFG_FILT_RELEASE]);
        match = c_on && (r_cmd.op == sva_pkg::OP_ALL_OFF || r_note[r_idx] == r_cmd.note);
        n_on = c_on;
        n_a = c_a;
        n_f = c_f;
        n_akey = r_akey[r_idx];
        n_fkey = r_fkey[r_idx];
        if (r_cmd.op == sva_pkg::OP_TICK) begin
            if (c_on) begin
                n_a = t_a;
                n_f = t_f;
                n_on = !(t_a.level <= sva_pkg::QUIET_MAX && t_a.stage == sva_pkg::ST_RELEASE);
            end
        end else if (match) begin
            n_akey = 1'b0;
            n_fkey = 1'b0;
            if (c_a.stage == sva_pkg::ST_SUSTAIN) n_a.level = r_cfg[sva_pkg::CFG_AMP_SUSTAIN];
            if (c_f.stage == sva_pkg::ST_SUSTAIN) n_f.level = r_cfg[sva_pkg::CFG_FILT_SUSTAIN];
            n_a.stage = sva_pkg::ST_RELEASE;
            n_f.stage = sva_pkg::ST_RELEASE;
        end
        force_rel = c_on && (r_note[r_idx] == r_cmd.note) && !r_same_found;
        eff_stg = force_rel ? sva_pkg::ST_RELEASE : c_a.stage;
        if (r_free_found) pick = r_free_idx;
        else if (r_quiet_found) pick = r_quiet_idx;
        else if (r_rel_low >= sva_pkg::NEAR_FULL && r_min_low < r_rel_low) pick = r_min_idx;
        else pick = r_rel_idx;
    end

    always_comb begin
        o_res = '0;
        o_stat.res_push = 1'b0;
        o_stat.idle = (r_state == S_IDLE);
        if (r_state == S_SWEEP) begin
            o_stat.res_push = !i_res_full;
            o_res.kind = (r_cmd.op == sva_pkg::OP_TICK) ? sva_pkg::KIND_TICK
                                                         : sva_pkg::KIND_ACK;
            o_res.voice = 3'(r_idx);
            o_res.active = n_on;
            o_res.voice_note = r_note[r_idx];
            o_res.voice_velocity = r_vel[r_idx];
            o_res.amp_level = n_a.level;
            o_res.filter_level = n_f.level;
            o_res.amp_stage = n_a.stage;
            o_res.last = last_idx;
        end else if (r_state == S_ASSIGN) begin
            o_stat.res_push = !i_res_full;
            o_res.kind = sva_pkg::KIND_ASSIGN;
            o_res.voice = 3'(pick);
            o_res.active = 1'b1;
            o_res.voice_note = r_cmd.note;
            o_res.voice_velocity = r_cmd.velocity;
            o_res.amp_stage = sva_pkg::ST_ATTACK;
            o_res.last = 1'b1;
        end
    end

    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx <= '0;
            for (int i = 0; i < sva_pkg::CFG_COUNT; i++) r_cfg[i] <= sva_pkg::CFG_RESET[i];
            for (int v = 0; v < VOICES; v++) begin
                r_on[v] <= 1'b0;
                r_note[v] <= '0;
                r_vel[v] <= '0;
                r_alvl[v] <= '0;
                r_astg[v] <= sva_pkg::ST_ATTACK;
                r_akey[v] <= 1'b0;
                r_flvl[v] <= '0;
                r_fstg[v] <= sva_pkg::ST_ATTACK;
                r_fkey[v] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) r_cfg[i_cfg_idx] <= cfg_sat;
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_idx <= '0;
                        r_same_found <= 1'b0;
                        r_free_found <= 1'b0;
                        r_quiet_found <= 1'b0;
                        r_free_idx <= '0;
                        r_quiet_idx <= '0;
                        r_rel_idx <= '0;
                        r_min_idx <= '0;
                        r_rel_low <= sva_pkg::FULL_LEVEL;
                        r_min_low <= 16'hFFFF;
                        r_state <= (i_cmd.op == sva_pkg::OP_NOTE_ON) ? S_SCAN : S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (!i_res_full) begin
                        r_on[r_idx] <= n_on;
                        r_alvl[r_idx] <= n_a.level;
                        r_astg[r_idx] <= n_a.stage;
                        r_akey[r_idx] <= n_akey;
                        r_flvl[r_idx] <= n_f.level;
                        r_fstg[r_idx] <= n_f.stage;
                        r_fkey[r_idx] <= n_fkey;
                        if (last_idx) r_state <= S_IDLE;
                        else r_idx <= r_idx + 1'b1;
                    end
                end
                S_SCAN: begin
                    if (force_rel) begin
                        r_same_found <= 1'b1;
                        r_akey[r_idx] <= 1'b0;
                        r_fkey[r_idx] <= 1'b0;
                        r_astg[r_idx] <= sva_pkg::ST_RELEASE;
                        r_fstg[r_idx] <= sva_pkg::ST_RELEASE;
                    end
                    if (!c_on && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free_idx <= r_idx;
                    end
                    if (eff_stg == sva_pkg::ST_RELEASE && c_a.level <= sva_pkg::QUIET_MAX
                        && !r_quiet_found) begin
                        r_quiet_found <= 1'b1;
                        r_quiet_idx <= r_idx;
                    end
                    if (eff_stg == sva_pkg::ST_RELEASE && c_a.level < r_rel_low) begin
                        r_rel_low <= c_a.level;
                        r_rel_idx <= r_idx;
                    end
                    if (c_a.level < r_min_low) begin
                        r_min_low <= c_a.level;
                        r_min_idx <= r_idx;
                    end
                    if (last_idx) r_state <= S_ASSIGN;
                    else r_idx <= r_idx + 1'b1;
                end
                S_ASSIGN: begin
                    if (!i_res_full) begin
                        r_on[pick] <= 1'b1;
                        r_note[pick] <= r_cmd.note;
                        r_vel[pick] <= r_cmd.velocity;
                        r_alvl[pick] <= '0;
                        r_astg[pick] <= sva_pkg::ST_ATTACK;
                        r_akey[pick] <= 1'b1;
                        r_flvl[pick] <= '0;
                        r_fstg[pick] <= sva_pkg::ST_ATTACK;
                        r_fkey[pick] <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ sv/synth_voice_allocator_adsr_top.sv @@
// Top level of the polyphonic voice allocator with ADSR envelopes.
// Depends on sva_pkg, sva_fifo and sva_engine.

// The block manages VOICES voice slots, each with an amplitude and a filter envelope in
// unsigned Q1.15. Commands enter through a two-beat input queue (push/full) and results
// leave through a two-beat result queue (empty/pop), so either side may stall without
// stalling the other. The back-end sequencer visits one voice slot per cycle, though a
// sweep waits while the result queue is full: a tick, note-off or all-notes-off yields
// VOICES result beats, slots in order, the final one marked last; a note-on scans the
// slots, then assigns one and yields a single beat. Between commands the sequencer
// returns to idle to take the next command from the input queue. Configuration
// registers take effect at the write edge and may be written only while the block is
// idle; writes above 1.0 are saturated to 1.0.
module synth_voice_allocator_adsr_top #(
    parameter int VOICES = sva_pkg::VOICES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  sva_pkg::t_in_item          i_item,
    output logic                       empty,
    input  logic                       pop,
    output sva_pkg::t_out_item         o_result,
    input  logic                       i_cfg_we,
    input  logic [sva_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [15:0]                i_cfg_data
);
    sva_pkg::t_in_item cmd;
    logic cmd_empty;
    logic cmd_take;
    sva_pkg::t_out_item res;
    logic res_full;
    sva_pkg::t_eng_stat stat;

    // Front end: command queue between the input side and the sequencer.
    sva_fifo #(.T(sva_pkg::t_in_item), .DEPTH(sva_pkg::QUEUE_DEPTH)) u_cmd_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(i_item), .o_full(full),
        .i_pop(cmd_take), .o_data(cmd), .o_empty(cmd_empty)
    );

    // Back end: slot state, configuration and the slot sequencer.
    sva_engine #(.VOICES(VOICES)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_cmd_valid(!cmd_empty), .i_cmd(cmd), .o_cmd_take(cmd_take),
        .o_res(res), .i_res_full(res_full), .o_stat(stat)
    );

    // Result queue: finished beats wait here while the consumer holds off.
    sva_fifo #(.T(sva_pkg::t_out_item), .DEPTH(sva_pkg::QUEUE_DEPTH)) u_res_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(stat.res_push), .i_data(res), .o_full(res_full),
        .i_pop(pop), .o_data(o_result), .o_empty(empty)
    );

    // The sequencer must never offer a beat to a full result queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.res_push |-> !res_full) else $error("result pushed into full queue");

    // A waiting command is taken by an idle sequencer and makes it busy.
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stat.idle && !cmd_empty) |=> !stat.idle) else $error("command not taken");

    // Commands are only taken while the sequencer is idle.
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_take |-> stat.idle && !stat.res_push) else $error("command taken while busy");
endmodule
